FILE: rtl/core/edid_pkg.sv
// Package for the EDID base block generator: config layout, byte sums and fixed bytes.
`default_nettype none
package edid_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PIXEL_CLOCK = 3'd0;
    localparam logic [2:0] REG_HORIZONTAL  = 3'd1;
    localparam logic [2:0] REG_VERTICAL    = 3'd2;
    localparam logic [2:0] REG_SYNC        = 3'd3;
    localparam logic [2:0] REG_VENDOR      = 3'd4;
    localparam logic [2:0] REG_NAME_LOW    = 3'd5;
    localparam logic [2:0] REG_NAME_HIGH   = 3'd6;

    localparam int CFG_DATA_W = 48;
    localparam int CHARS_PER_REG = 6;

    // Fixed byte values of the block
    localparam logic [7:0] HEADER_FILL   = 8'hff;
    localparam logic [7:0] STRUCT_VER    = 8'h01;
    localparam logic [7:0] STRUCT_REV    = 8'h03;
    localparam logic [7:0] INPUT_DEF     = 8'h80;
    localparam logic [7:0] GAMMA_CODE    = 8'hff;
    localparam logic [7:0] FEATURE_BITS  = 8'h06;
    localparam logic [7:0] STD_UNUSED    = 8'h01;
    localparam logic [7:0] DTD_FLAGS     = 8'h1e;
    localparam logic [7:0] NAME_TAG      = 8'hfc;
    localparam logic [7:0] UNUSED_TAG    = 8'h10;
    localparam logic [7:0] NAME_TERM     = 8'h0a;
    localparam logic [7:0] NAME_PAD      = 8'h20;

    // Name field holds a terminator plus this many char or pad slots
    localparam logic [3:0] NAME_SLOTS = 4'd12;

    // Sum of all bytes that never change, terminator included
    localparam logic [7:0] FIXED_SUM = 8'(
        6 * int'(HEADER_FILL) + int'(STRUCT_VER) + int'(STRUCT_REV) +
        int'(INPUT_DEF) + int'(GAMMA_CODE) + int'(FEATURE_BITS) +
        16 * int'(STD_UNUSED) + int'(DTD_FLAGS) + int'(NAME_TAG) +
        int'(NAME_TERM) + 2 * int'(UNUSED_TAG));

    typedef struct packed {
        logic [15:0] pixel_clock_10khz;
        logic [23:0] horizontal_geometry;
        logic [23:0] vertical_geometry;
        logic [31:0] sync_geometry;
        logic [38:0] vendor_identity;
        logic [47:0] name_chars_low;
        logic [47:0] name_chars_high;
    } cfg_t;

    // Byte sums per register, plus the resolved name length and char sum
    typedef struct packed {
        logic [7:0] pclk_sum;
        logic [7:0] horiz_sum;
        logic [7:0] vert_sum;
        logic [7:0] sync_sum;
        logic [7:0] vendor_sum;
        logic [7:0] name_sum;
        logic [3:0] name_len;
    } sums_t;

    // Image size in mm from active count: 10 * active / 64
    function automatic logic [9:0] image_size(input logic [11:0] active);
        logic [15:0] prod;
        prod = {1'b0, active, 3'b000} + {3'b000, active, 1'b0};
        return prod[15:6];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/edid_cfg_regs.sv
// Configuration registers with per-register byte sums captured on each write.
`default_nettype none
module edid_cfg_regs #(
    parameter int NAME_CHARS = 12
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write,
    input  wire  [2:0]                     cfg_index,
    input  wire  [edid_pkg::CFG_DATA_W-1:0] cfg_data,
    output edid_pkg::cfg_t                 cfg,
    output edid_pkg::sums_t                sums
);
    import edid_pkg::*;

    localparam int LOW_CHARS  = (NAME_CHARS < CHARS_PER_REG) ? NAME_CHARS : CHARS_PER_REG;
    localparam int HIGH_CHARS = (NAME_CHARS > CHARS_PER_REG) ? NAME_CHARS - CHARS_PER_REG : 0;

    // Length up to first zero char (or limit) and sum of the chars before it
    function automatic logic [10:0] name_prefix(input logic [47:0] chars, input int limit);
        logic [7:0] sum;
        logic [2:0] len;
        logic       found;
        sum   = 8'h00;
        len   = 3'(limit);
        found = 1'b0;
        for (int k = 0; k < CHARS_PER_REG; k++)
        begin
            if (k < limit && !found)
            begin
                if (chars[8*k +: 8] == 8'h00)
                begin
                    found = 1'b1;
                    len   = 3'(k);
                end
                else
                begin
                    sum = sum + chars[8*k +: 8];
                end
            end
        end
        return {len, sum};
    endfunction

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [7:0] pclk_sum_reg,   pclk_sum_next;
    logic [7:0] horiz_sum_reg,  horiz_sum_next;
    logic [7:0] vert_sum_reg,   vert_sum_next;
    logic [7:0] sync_sum_reg,   sync_sum_next;
    logic [7:0] vendor_sum_reg, vendor_sum_next;
    logic [7:0] low_sum_reg,    low_sum_next;
    logic [2:0] low_len_reg,    low_len_next;
    logic [7:0] high_sum_reg,   high_sum_next;
    logic [2:0] high_len_reg,   high_len_next;

    // Byte sums of the incoming write data, one per register kind
    logic [11:0] w_active, w_blank;
    logic [9:0]  w_size;
    logic [9:0]  w_hso, w_hsw;
    logic [5:0]  w_vso, w_vsw;
    logic [7:0]  w_geom_common;
    logic [7:0]  w_pclk_sum, w_horiz_sum, w_vert_sum, w_sync_sum, w_vendor_sum;
    logic [10:0] w_low_prefix, w_high_prefix;

    always_comb
    begin
        w_active = cfg_data[11:0];
        w_blank  = cfg_data[23:12];
        w_size   = image_size(w_active);
        w_geom_common = w_active[7:0] + w_blank[7:0] + {w_active[11:8], w_blank[11:8]}
                      + w_size[7:0] + {2'b00, w_active[11:6]};
        w_horiz_sum  = w_geom_common + {2'b00, w_size[9:8], 4'h0};
        w_vert_sum   = w_geom_common + {6'h00, w_size[9:8]};
        w_pclk_sum   = cfg_data[7:0] + cfg_data[15:8];
        w_hso = cfg_data[9:0];
        w_hsw = cfg_data[19:10];
        w_vso = cfg_data[25:20];
        w_vsw = cfg_data[31:26];
        w_sync_sum   = w_hso[7:0] + w_hsw[7:0] + {w_vso[3:0], w_vsw[3:0]}
                     + {w_hso[9:8], w_hsw[9:8], w_vso[5:4], w_vsw[5:4]};
        w_vendor_sum = {1'b0, cfg_data[14:8]} + cfg_data[7:0] + cfg_data[22:15]
                     + cfg_data[30:23] + cfg_data[38:31];
        w_low_prefix  = name_prefix(cfg_data, LOW_CHARS);
        w_high_prefix = name_prefix(cfg_data, HIGH_CHARS);
    end

    // Register write decode
    always_comb
    begin
        cfg_next        = cfg_reg;
        pclk_sum_next   = pclk_sum_reg;
        horiz_sum_next  = horiz_sum_reg;
        vert_sum_next   = vert_sum_reg;
        sync_sum_next   = sync_sum_reg;
        vendor_sum_next = vendor_sum_reg;
        low_sum_next    = low_sum_reg;
        low_len_next    = low_len_reg;
        high_sum_next   = high_sum_reg;
        high_len_next   = high_len_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PIXEL_CLOCK:
                begin
                    cfg_next.pixel_clock_10khz = cfg_data[15:0];
                    pclk_sum_next = w_pclk_sum;
                end
                REG_HORIZONTAL:
                begin
                    cfg_next.horizontal_geometry = cfg_data[23:0];
                    horiz_sum_next = w_horiz_sum;
                end
                REG_VERTICAL:
                begin
                    cfg_next.vertical_geometry = cfg_data[23:0];
                    vert_sum_next = w_vert_sum;
                end
                REG_SYNC:
                begin
                    cfg_next.sync_geometry = cfg_data[31:0];
                    sync_sum_next = w_sync_sum;
                end
                REG_VENDOR:
                begin
                    cfg_next.vendor_identity = cfg_data[38:0];
                    vendor_sum_next = w_vendor_sum;
                end
                REG_NAME_LOW:
                begin
                    cfg_next.name_chars_low = cfg_data;
                    low_sum_next = w_low_prefix[7:0];
                    low_len_next = w_low_prefix[10:8];
                end
                REG_NAME_HIGH:
                begin
                    cfg_next.name_chars_high = cfg_data;
                    high_sum_next = w_high_prefix[7:0];
                    high_len_next = w_high_prefix[10:8];
                end
                default:
                begin
                    // index beyond the list: write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            pclk_sum_reg   <= 8'h00;
            horiz_sum_reg  <= 8'h00;
            vert_sum_reg   <= 8'h00;
            sync_sum_reg   <= 8'h00;
            vendor_sum_reg <= 8'h00;
            low_sum_reg    <= 8'h00;
            low_len_reg    <= 3'd0;
            high_sum_reg   <= 8'h00;
            high_len_reg   <= 3'd0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            pclk_sum_reg   <= pclk_sum_next;
            horiz_sum_reg  <= horiz_sum_next;
            vert_sum_reg   <= vert_sum_next;
            sync_sum_reg   <= sync_sum_next;
            vendor_sum_reg <= vendor_sum_next;
            low_sum_reg    <= low_sum_next;
            low_len_reg    <= low_len_next;
            high_sum_reg   <= high_sum_next;
            high_len_reg   <= high_len_next;
        end
    end

    // Name continues into the high chars only when the low chars hold no zero
    logic low_full;
    assign low_full = (low_len_reg == 3'(LOW_CHARS));

    assign cfg = cfg_reg;
    always_comb
    begin
        sums.pclk_sum   = pclk_sum_reg;
        sums.horiz_sum  = horiz_sum_reg;
        sums.vert_sum   = vert_sum_reg;
        sums.sync_sum   = sync_sum_reg;
        sums.vendor_sum = vendor_sum_reg;
        sums.name_sum   = low_sum_reg + (low_full ? high_sum_reg : 8'h00);
        sums.name_len   = {1'b0, low_len_reg} + (low_full ? {1'b0, high_len_reg} : 4'd0);
    end

endmodule
`default_nettype wire

FILE: rtl/core/edid_checksum.sv
// Checksum register: two's complement of the sum of bytes 0 to 126.
`default_nettype none
module edid_checksum (
    input  wire                   clk,
    input  wire edid_pkg::sums_t  sums,
    output logic [7:0]            checksum
);
    import edid_pkg::*;

    logic [7:0] checksum_reg;
    logic [7:0] checksum_next;
    logic [3:0] pad_count;
    logic [7:0] total;

    // Fixed bytes, per-register sums and the padding spaces
    always_comb
    begin
        pad_count = NAME_SLOTS - sums.name_len;
        total = FIXED_SUM + sums.pclk_sum + sums.horiz_sum + sums.vert_sum
              + sums.sync_sum + sums.vendor_sum + sums.name_sum
              + {pad_count[2:0], 5'b00000};
        checksum_next = ~total + 8'h01;
    end

    always_ff @(posedge clk)
    begin
        checksum_reg <= checksum_next;
    end

    assign checksum = checksum_reg;

endmodule
`default_nettype wire

FILE: rtl/core/edid_byte_mux.sv
// Byte selection for offsets 0 to 126 of the base block.
`default_nettype none
module edid_byte_mux (
    input  wire  [6:0]            byte_index,
    input  wire edid_pkg::cfg_t   cfg,
    input  wire  [3:0]            name_len,
    output logic [7:0]            data_byte
);
    import edid_pkg::*;

    logic [11:0] ha, hb, va, vb;
    logic [9:0]  his, vis;
    logic [9:0]  hso, hsw;
    logic [5:0]  vso, vsw;
    logic [11:0][7:0] chars;

    always_comb
    begin
        ha  = cfg.horizontal_geometry[11:0];
        hb  = cfg.horizontal_geometry[23:12];
        va  = cfg.vertical_geometry[11:0];
        vb  = cfg.vertical_geometry[23:12];
        his = image_size(ha);
        vis = image_size(va);
        hso = cfg.sync_geometry[9:0];
        hsw = cfg.sync_geometry[19:10];
        vso = cfg.sync_geometry[25:20];
        vsw = cfg.sync_geometry[31:26];
        chars = {cfg.name_chars_high, cfg.name_chars_low};
    end

    // Detailed timing descriptor bytes
    function automatic logic [7:0] timing_byte(input logic [4:0] o);
        logic [7:0] b;
        unique case (o)
            5'd0:    b = cfg.pixel_clock_10khz[7:0];
            5'd1:    b = cfg.pixel_clock_10khz[15:8];
            5'd2:    b = ha[7:0];
            5'd3:    b = hb[7:0];
            5'd4:    b = {ha[11:8], hb[11:8]};
            5'd5:    b = va[7:0];
            5'd6:    b = vb[7:0];
            5'd7:    b = {va[11:8], vb[11:8]};
            5'd8:    b = hso[7:0];
            5'd9:    b = hsw[7:0];
            5'd10:   b = {vso[3:0], vsw[3:0]};
            5'd11:   b = {hso[9:8], hsw[9:8], vso[5:4], vsw[5:4]};
            5'd12:   b = his[7:0];
            5'd13:   b = vis[7:0];
            5'd14:   b = {2'b00, his[9:8], 2'b00, vis[9:8]};
            5'd17:   b = DTD_FLAGS;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Monitor name descriptor bytes
    function automatic logic [7:0] name_byte(input logic [4:0] o);
        logic [7:0] b;
        logic [3:0] d;
        d = 4'(o - 5'd5);
        if (o == 5'd3)
            b = NAME_TAG;
        else if (o < 5'd5)
            b = 8'h00;
        else if (d < name_len)
            b = chars[d];
        else if (d == name_len)
            b = NAME_TERM;
        else
            b = NAME_PAD;
        return b;
    endfunction

    // Region decode over the block
    logic [6:0] t_off, n_off;
    always_comb
    begin
        t_off = byte_index - 7'd54;
        n_off = byte_index - 7'd72;
        priority if (byte_index < 7'd8)
            data_byte = (byte_index == 7'd0 || byte_index == 7'd7) ? 8'h00 : HEADER_FILL;
        else if (byte_index >= 7'd54 && byte_index < 7'd72)
            data_byte = timing_byte(t_off[4:0]);
        else if (byte_index >= 7'd72 && byte_index < 7'd90)
            data_byte = name_byte(n_off[4:0]);
        else if (byte_index >= 7'd90)
            data_byte = (byte_index == 7'd93 || byte_index == 7'd111) ? UNUSED_TAG : 8'h00;
        else if (byte_index >= 7'd38)
            data_byte = STD_UNUSED;
        else
        begin
            unique case (byte_index)
                7'd8:    data_byte = {1'b0, cfg.vendor_identity[14:8]};
                7'd9:    data_byte = cfg.vendor_identity[7:0];
                7'd10:   data_byte = cfg.vendor_identity[22:15];
                7'd11:   data_byte = cfg.vendor_identity[30:23];
                7'd17:   data_byte = cfg.vendor_identity[38:31];
                7'd18:   data_byte = STRUCT_VER;
                7'd19:   data_byte = STRUCT_REV;
                7'd20:   data_byte = INPUT_DEF;
                7'd21:   data_byte = {2'b00, ha[11:6]};
                7'd22:   data_byte = {2'b00, va[11:6]};
                7'd23:   data_byte = GAMMA_CODE;
                7'd24:   data_byte = FEATURE_BITS;
                default: data_byte = 8'h00;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/edid_base_block_generator_core.sv
// Top level of the EDID 1.3 base block generator: request pipeline and submodules.
`default_nettype none
// Serves a 128-byte EDID 1.3 base block one byte per request. A request
// (start high; busy is always low) is taken every cycle. Its byte is put on
// data_byte with done high for one cycle once the request, byte and result
// stages have registered it in turn: one byte per cycle, three
// register stages from port to port. There is no way to hold results off, so
// the receiver must take each byte in the cycle it is shown. Byte 127 is the
// checksum; it comes from a register that is refreshed every cycle from byte
// sums captured at each configuration write, so a request may follow a write
// right away. Writes use cfg_write, cfg_index and cfg_data (low bits of
// cfg_data for narrow registers); indexes past the last register are ignored.
module edid_base_block_generator_core #(
    parameter int NAME_CHARS = 12
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [6:0]  byte_index,
    output logic        done,
    output logic [7:0]  data_byte,
    input  wire         cfg_write,
    input  wire  [2:0]  cfg_index,
    input  wire  [47:0] cfg_data
);
    import edid_pkg::*;

    localparam logic [6:0] CHECKSUM_INDEX = 7'd127;

    cfg_t       cfg;
    sums_t      sums;
    logic [7:0] checksum;
    logic [7:0] mux_byte;
    logic       accept;

    edid_cfg_regs #(
        .NAME_CHARS (NAME_CHARS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .sums      (sums)
    );

    edid_checksum u_checksum (
        .clk      (clk),
        .sums     (sums),
        .checksum (checksum)
    );

    // Request stage
    logic       req_valid_reg, req_valid_next;
    logic [6:0] req_index_reg;
    // Byte stage
    logic       sel_valid_reg, sel_valid_next;
    logic       sel_ck_reg;
    logic [7:0] sel_byte_reg;
    // Result stage
    logic       done_reg;
    logic [7:0] data_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    edid_byte_mux u_mux (
        .byte_index (req_index_reg),
        .cfg        (cfg),
        .name_len   (sums.name_len),
        .data_byte  (mux_byte)
    );

    assign req_valid_next = accept;
    assign sel_valid_next = req_valid_reg;

    // Strobes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            sel_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            sel_valid_reg <= sel_valid_next;
            done_reg      <= sel_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        req_index_reg <= byte_index;
        sel_byte_reg  <= mux_byte;
        sel_ck_reg    <= (req_index_reg == CHECKSUM_INDEX);
        data_reg      <= sel_ck_reg ? checksum : sel_byte_reg;
    end

    assign done      = done_reg;
    assign data_byte = data_reg;

`ifndef NO_ASSERTIONS
    // Each request gives a byte, flagged by done
    a_req_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not produce a result");

    // No byte without an earlier request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a request");

    // Header start byte is zero whatever the configuration
    a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_index == 7'd0) |-> ##3 (done && data_byte == 8'h00))
        else $error("header byte 0 not zero");

    // Header fill byte 3 is 0xff
    a_header_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_index == 7'd3) |-> ##3 (data_byte == HEADER_FILL))
        else $error("header fill byte wrong");
`endif

endmodule
`default_nettype wire
